// ===== design/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and codes of the telemetry channel table: item kinds,
// result kinds, the stored entry record, the result word and the
// control groups between the sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tct_pkg;

  // item kinds on the input side
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // result kinds on the output side
  localparam logic [1:0] RES_WRITE = 2'd0;
  localparam logic [1:0] RES_READ  = 2'd1;
  localparam logic [1:0] RES_EMIT  = 2'd2;

  // byte count ceiling of a stored value
  localparam logic [3:0] MAX_BYTES = 4'd8;

  // emitted words per tick
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_TICK,
    ST_FETCH
  } tct_state_t;

  typedef struct packed {
    logic [31:0] chan;
    logic [63:0] tstamp;
    logic [63:0] value;
    logic [3:0]  nbytes;
  } tct_entry_t;

  typedef struct packed {
    logic [1:0] rkind;
    logic       found;
    logic       full;
    tct_entry_t ent;
    logic       last;
  } tct_result_t;

  // top level to sequencer
  typedef struct packed {
    logic emit_enable;
    logic out_free;
  } tct_ctl_t;

  // sequencer to top level
  typedef struct packed {
    logic idle;
    logic push;
  } tct_status_t;

endpackage

`default_nettype wire

// ===== design/tct_store.sv =====
// ----------------------------------------------------------------------------
// tct_store
// Entry record memory: one write port, one read port with registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_store #(
  parameter int ENTRIES = 32,
  parameter int AW      = 5
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  tct_pkg::tct_entry_t  wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output tct_pkg::tct_entry_t  rdata
);

  tct_pkg::tct_entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/tct_ctrl.sv =====
// ----------------------------------------------------------------------------
// tct_ctrl
// Sequencer of the channel table: walks the entries one a cycle through
// the store on a write or read scan (a tick waits on the output), with one
// shared id comparator, and keeps the used and updated flags in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_ctrl #(
  parameter int ENTRIES = 32,
  parameter int AW      = 5
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_kind,
  input  tct_pkg::tct_entry_t  in_item,
  input  tct_pkg::tct_ctl_t    ctl,
  output tct_pkg::tct_status_t status,
  output tct_pkg::tct_result_t result,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output tct_pkg::tct_entry_t  mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  tct_pkg::tct_entry_t  mem_rdata
);

  localparam int IW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] END_IDX = IW'(ENTRIES);
  localparam logic [AW-1:0] LAST_A  = AW'(ENTRIES - 1);
  localparam logic [tct_pkg::CNT_W-1:0] CNT_LAST = tct_pkg::CNT_W'(tct_pkg::MAX_RESULTS - 1);

  tct_pkg::tct_state_t state_r, state_nxt;
  logic [ENTRIES-1:0]  used_r, used_nxt;
  logic [ENTRIES-1:0]  upd_r, upd_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       pidx_r, pidx_nxt;
  logic                pv_r, pv_nxt;
  logic [1:0]          kind_r, kind_nxt;
  tct_pkg::tct_entry_t item_r, item_nxt;
  logic                hit_r, hit_nxt;
  logic [AW-1:0]       hit_idx_r, hit_idx_nxt;
  logic                free_r, free_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;
  tct_pkg::tct_entry_t res_r, res_nxt;
  logic [tct_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [AW-1:0]      idx_a;
  logic               in_range;
  logic [ENTRIES-1:0] pend;
  logic [ENTRIES-1:0] above;
  logic               cmp_hit;
  logic               scan_done;
  logic               emit_last;
  logic               full;
  logic [AW-1:0]      slot;
  logic               accept;

  assign idx_a    = idx_r[AW-1:0];
  assign in_range = idx_r < END_IDX;
  assign pend     = used_r & upd_r;
  assign accept   = (state_r == tct_pkg::ST_IDLE) && in_valid;

  // the shared comparator: one stored id against the item's id
  assign cmp_hit   = pv_r && used_r[pidx_r] && (mem_rdata.chan == item_r.chan);
  assign scan_done = pv_r && (cmp_hit || (pidx_r == LAST_A));

  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      above[j] = pend[j] && (IW'(j) > idx_r);
    end
  end

  assign emit_last = (above == '0) || (cnt_r == CNT_LAST);
  assign full      = !hit_r && !free_r;
  assign slot      = hit_r ? hit_idx_r : free_idx_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tct_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_kind) inside
            tct_pkg::KIND_WRITE, tct_pkg::KIND_READ: state_nxt = tct_pkg::ST_SCAN;
            tct_pkg::KIND_TICK: begin
              state_nxt = ctl.emit_enable ? tct_pkg::ST_TICK : tct_pkg::ST_IDLE;
            end
            default: state_nxt = tct_pkg::ST_IDLE;
          endcase
        end
      end
      tct_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = tct_pkg::ST_FINISH;
      end
      tct_pkg::ST_FINISH: begin
        if (ctl.out_free) state_nxt = tct_pkg::ST_IDLE;
      end
      tct_pkg::ST_TICK: begin
        if (!in_range) begin
          state_nxt = tct_pkg::ST_IDLE;
        end else if (pend[idx_a]) begin
          state_nxt = tct_pkg::ST_FETCH;
        end
      end
      tct_pkg::ST_FETCH: begin
        if (ctl.out_free) state_nxt = emit_last ? tct_pkg::ST_IDLE : tct_pkg::ST_TICK;
      end
      default: state_nxt = tct_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    used_nxt     = used_r;
    upd_nxt      = upd_r;
    idx_nxt      = idx_r;
    pidx_nxt     = pidx_r;
    pv_nxt       = pv_r;
    kind_nxt     = kind_r;
    item_nxt     = item_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    res_nxt      = res_r;
    cnt_nxt      = cnt_r;
    mem_we       = 1'b0;
    mem_waddr    = slot;
    mem_wdata    = item_r;
    mem_re       = 1'b0;
    mem_raddr    = idx_a;
    result       = '0;
    status.idle  = (state_r == tct_pkg::ST_IDLE);
    status.push  = 1'b0;

    unique case (state_r)
      tct_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind;
          item_nxt = in_item;
          if (in_item.nbytes > tct_pkg::MAX_BYTES) item_nxt.nbytes = tct_pkg::MAX_BYTES;
          idx_nxt  = '0;
          pv_nxt   = 1'b0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          cnt_nxt  = '0;
          res_nxt  = '0;
        end
      end
      tct_pkg::ST_SCAN: begin
        if (in_range) begin
          mem_re   = 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = idx_a;
          idx_nxt  = idx_r + 1'b1;
          if (!used_r[idx_a] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = idx_a;
          end
        end else begin
          pv_nxt = 1'b0;
        end
        if (cmp_hit) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pidx_r;
          res_nxt     = mem_rdata;
        end
      end
      tct_pkg::ST_FINISH: begin
        result.last = 1'b1;
        if (kind_r == tct_pkg::KIND_WRITE) begin
          result.rkind = tct_pkg::RES_WRITE;
          result.full  = full;
        end else begin
          result.rkind    = tct_pkg::RES_READ;
          result.found    = hit_r;
          result.ent      = res_r;
          result.ent.chan = item_r.chan;
        end
        if (ctl.out_free) begin
          status.push = 1'b1;
          if (kind_r == tct_pkg::KIND_WRITE && !full) begin
            mem_we        = 1'b1;
            used_nxt[slot] = 1'b1;
            upd_nxt[slot]  = 1'b1;
          end
        end
      end
      tct_pkg::ST_TICK: begin
        if (in_range) begin
          if (pend[idx_a]) begin
            mem_re = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      tct_pkg::ST_FETCH: begin
        result.rkind = tct_pkg::RES_EMIT;
        result.ent   = mem_rdata;
        result.last  = emit_last;
        if (ctl.out_free) begin
          status.push    = 1'b1;
          upd_nxt[idx_a] = 1'b0;
          cnt_nxt        = cnt_r + 1'b1;
          idx_nxt        = idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tct_pkg::ST_IDLE;
      used_r  <= '0;
      upd_r   <= '0;
      idx_r   <= '0;
      pv_r    <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      upd_r   <= upd_nxt;
      idx_r   <= idx_nxt;
      pv_r    <= pv_nxt;
      hit_r   <= hit_nxt;
      free_r  <= free_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    kind_r     <= kind_nxt;
    item_r     <= item_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    res_r      <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== design/telemetry_channel_table.sv =====
// ----------------------------------------------------------------------------
// telemetry_channel_table
// Linearly searched table of telemetry channels with write, read and
// tick items, and an output register towards the result stream.
// ----------------------------------------------------------------------------
// write and read: one stored entry per cycle through the store read port, fewer entries when
// the id matches early, then one result word; in_tready rises as that word reaches the output
// tick: skips entries without a pending update and emits one word per updated entry, at most
// 32 words, and none while emit_enable is low; output stalls hold the sequencer back
// one item at a time: in_tready is high only while the sequencer is idle
// reset clears the used and updated flags at once (no clearing pass) and sets emit_enable
`default_nettype none

module telemetry_channel_table #(
  parameter int ENTRIES = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input words
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [167:0] in_tdata,   // chan_id, time_stamp, value_word, value_bytes, zero pad
  input  wire logic [1:0]   in_tuser,   // kind
  // result words
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [167:0]      out_tdata,  // out_chan_id, out_time, out_value, out_bytes, zero pad
  output logic [3:0]        out_tuser,  // result_kind, found, table_full
  output logic              out_tlast,
  // configuration
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_data    // emit_enable
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  tct_pkg::tct_entry_t  in_item;
  tct_pkg::tct_ctl_t    ctl;
  tct_pkg::tct_status_t status;
  tct_pkg::tct_result_t result;
  tct_pkg::tct_result_t out_r;
  tct_pkg::tct_entry_t  mem_wdata;
  tct_pkg::tct_entry_t  mem_rdata;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic                 emit_en_r;
  logic                 out_valid_r;

  assign in_item.chan   = in_tdata[31:0];
  assign in_item.tstamp = in_tdata[95:32];
  assign in_item.value  = in_tdata[159:96];
  assign in_item.nbytes = in_tdata[163:160];

  assign ctl.emit_enable = emit_en_r;
  assign ctl.out_free    = !out_valid_r || out_tready;

  assign in_tready = status.idle;
  assign cfg_ready = 1'b1;

  tct_store #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tct_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser),
    .in_item   (in_item),
    .ctl       (ctl),
    .status    (status),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      emit_en_r <= cfg_data;
    end
  end

  // output register: a word waits here while the sequencer moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (status.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.push) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r.ent.nbytes, out_r.ent.value, out_r.ent.tstamp,
                       out_r.ent.chan};
  assign out_tuser  = {out_r.full, out_r.found, out_r.rkind};
  assign out_tlast  = out_r.last;

`ifndef SYNTHESIS
  a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    status.push |-> (!out_valid_r || out_tready))
    else $error("result pushed into an occupied output register");

  a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !status.push)
    else $error("result pushed while idle");

  a_busy_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == tct_pkg::KIND_WRITE ||
     in_tuser == tct_pkg::KIND_READ)) |=> !in_tready)
    else $error("write or read accepted without a scan");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] != tct_pkg::RES_EMIT) |-> out_tlast)
    else $error("write status or read answer without last");
`endif

endmodule

`default_nettype wire
